// ===== rtl/fcsr_pkg.sv =====
// Shared constants, codes and types of the fault code scan and rotate block.
package fcsr_pkg;

  localparam int WORD_W     = 64;
  localparam int FAULT_BITS = 64;
  localparam int LIST_DEPTH = 64;
  localparam int CODE_W     = 7;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int BIT_IDX_W  = $clog2(FAULT_BITS);

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_SEND    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              wr;
    logic [CODE_W-1:0] code;
    logic              done;
  } scan_t;

endpackage

// ===== rtl/fcsr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module fcsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fcsr_scan.sv =====
// Bit-serial scanner that shifts the fault word out one flag per cycle.
module fcsr_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fcsr_pkg::WORD_W-1:0] word,
  output fcsr_pkg::scan_t            scan
);

  logic [fcsr_pkg::FAULT_BITS-1:0] shreg;
  logic [fcsr_pkg::BIT_IDX_W-1:0]  idx;
  logic                            busy;
  logic                            last;

  assign last = (idx == fcsr_pkg::BIT_IDX_W'(fcsr_pkg::FAULT_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= word[fcsr_pkg::FAULT_BITS-1:0];
      idx   <= '0;
    end else if (busy) begin
      shreg <= shreg >> 1;
      idx   <= idx + fcsr_pkg::BIT_IDX_W'(1);
    end
  end

  assign scan.wr   = busy & shreg[0];
  assign scan.code = fcsr_pkg::CODE_W'(idx) + fcsr_pkg::CODE_W'(1);
  assign scan.done = busy & last;

endmodule

// ===== rtl/fault_code_scan_and_rotate.sv =====
// Top level of the fault code scan and rotate block.
// An input word is either a capture (operation 0) or a send (operation 1).
// A capture with key_on set and no round pending scans fault_bits one bit
// per cycle from bit 0 upward and stores code n+1 for every set bit n.
// A send returns the most recently stored code, so codes leave highest
// first, and returns 0 once the list is empty.
// Every input word gives exactly one output word on the out channel.
// The block works on one word at a time and holds in_stall high while busy.
// A scanning capture gives its result once the bit-serial scan of the
// fault word is through; a send that reads the list waits for the
// registered RAM read. Any other word goes straight from idle to done.
// The result sits in an output register; while out_stall is high it holds,
// and the block waits before loading the next result.
// Synchronous reset empties the list, clears the pending round and drops
// out_valid; the list RAM needs no clearing.
module fault_code_scan_and_rotate (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            operation,
  input  logic                            key_on,
  input  logic [fcsr_pkg::WORD_W-1:0]     fault_bits,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fcsr_pkg::CODE_W-1:0]     fault_code,
  output logic [fcsr_pkg::CNT_W-1:0]      codes_left,
  output logic                            round_pending
);

  fcsr_pkg::state_t             state;
  fcsr_pkg::state_t             state_next;
  logic [fcsr_pkg::CNT_W-1:0]   count;
  logic [fcsr_pkg::CNT_W-1:0]   count_next;
  logic [fcsr_pkg::CNT_W-1:0]   count_dec;
  logic                         pending;
  logic                         pending_next;
  logic [fcsr_pkg::CODE_W-1:0]  res_code;
  logic [fcsr_pkg::CODE_W-1:0]  res_code_next;
  logic                         load_out;
  logic                         scan_start;
  logic                         ram_we;
  logic [fcsr_pkg::CODE_W-1:0]  ram_rdata;
  fcsr_pkg::scan_t              scan;

  assign count_dec = count - fcsr_pkg::CNT_W'(1);
  assign in_stall  = (state != fcsr_pkg::ST_IDLE);

  fcsr_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .word  (fault_bits),
    .scan  (scan)
  );

  fcsr_ram #(
    .WIDTH (fcsr_pkg::CODE_W),
    .DEPTH (fcsr_pkg::LIST_DEPTH)
  ) u_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[fcsr_pkg::IDX_W-1:0]),
    .wdata (scan.code),
    .raddr (count_dec[fcsr_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= fcsr_pkg::ST_IDLE;
      count   <= '0;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    res_code <= res_code_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    pending_next  = pending;
    res_code_next = res_code;
    load_out      = 1'b0;
    scan_start    = 1'b0;
    ram_we        = 1'b0;
    unique case (state)
      fcsr_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (operation == fcsr_pkg::OP_CAPTURE && key_on && !pending) begin
            scan_start = 1'b1;
            state_next = fcsr_pkg::ST_SCAN;
          end else if (operation == fcsr_pkg::OP_SEND && count != '0) begin
            state_next = fcsr_pkg::ST_READ;
          end else begin
            res_code_next = '0;
            if (operation == fcsr_pkg::OP_SEND) begin
              pending_next = 1'b0;
            end
            state_next = fcsr_pkg::ST_DONE;
          end
        end
      end
      fcsr_pkg::ST_SCAN: begin
        ram_we = scan.wr;
        if (scan.wr) begin
          count_next = count + fcsr_pkg::CNT_W'(1);
        end
        if (scan.done) begin
          pending_next  = 1'b1;
          res_code_next = '0;
          state_next    = fcsr_pkg::ST_DONE;
        end
      end
      fcsr_pkg::ST_READ: begin
        res_code_next = ram_rdata;
        count_next    = count_dec;
        pending_next  = (count_dec != '0);
        state_next    = fcsr_pkg::ST_DONE;
      end
      fcsr_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = fcsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fcsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      fault_code    <= res_code;
      codes_left    <= count;
      round_pending <= pending;
    end
  end

endmodule

// ===== rtl/fcsr_checker.sv =====
// Port-level checker for the fault code scan and rotate block, with its bind.
module fcsr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [fcsr_pkg::CODE_W-1:0] fault_code,
  input logic [fcsr_pkg::CNT_W-1:0]  codes_left,
  input logic                        round_pending
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("An output word is valid right after reset.");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && !round_pending |-> codes_left == '0)
    else $error("Codes are left although no round is pending.");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fault_code <= fcsr_pkg::CODE_W'(fcsr_pkg::FAULT_BITS) &&
                  codes_left <= fcsr_pkg::CNT_W'(fcsr_pkg::LIST_DEPTH))
    else $error("A fault code or a count is out of range.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(fault_code) &&
                               $stable(codes_left) && $stable(round_pending))
    else $error("A stalled output word changed.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("A second input word was taken while one is in work.");

endmodule

bind fault_code_scan_and_rotate fcsr_checker u_fcsr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .fault_code    (fault_code),
  .codes_left    (codes_left),
  .round_pending (round_pending)
);
